// ===== hw/rtl/rss_pkg.sv =====
// Shared constants, types and controller codes for running_sample_statistics.
// Used by the channel interfaces, the controller, the datapath and its units.
package rss_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COUNT_BITS   = 16;
  localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
  localparam int SQS_BITS     = 64;
  localparam int PROD_BITS    = 2 * SAMPLE_BITS;
  localparam int SD_BITS      = SAMPLE_BITS - 1;
  localparam int ROOT_BITS    = SQS_BITS / 2;
  localparam int DIV_STEPS    = SQS_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic        [SUM_BITS-1:0]    usum_t;
  typedef logic        [SQS_BITS-1:0]    sqs_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic        [PROD_BITS-1:0]   uprod_t;
  typedef logic        [SD_BITS-1:0]     sd_t;
  typedef logic        [ROOT_BITS-1:0]   root_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam sd_t     SD_MAX     = '1;
  localparam sqs_t    ROOT_BIT0  = sqs_t'(1) << (SQS_BITS - 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic take;        // item accepted this cycle
    logic mul_mean;    // multiplier squares the mean instead of the sample
    logic div_start;
    logic div_sel_sq;  // divide sum of squares, else |sum|
    logic load_mean;
    logic root_start;
    logic load_sd;
    logic load_out;
    logic clear_acc;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic div_done;
    logic root_done;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    sample_t min_value;
    sample_t max_value;
    sample_t mean_value;
    sd_t     std_deviation;
    count_t  valid_count;
    logic    no_data;
    logic    count_overflow;
  } result_t;

endpackage

// ===== hw/rtl/rss_in_if.sv =====
// Input channel of running_sample_statistics: one sample item per handshake.
// Depends on rss_pkg.
interface rss_in_if;
  import rss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_value;
  logic    sample_present;
  logic    last_of_set;

  modport source (output valid, output sample_value, output sample_present,
                  output last_of_set, input ready);
  modport sink   (input valid, input sample_value, input sample_present,
                  input last_of_set, output ready);
endinterface

// ===== hw/rtl/rss_out_if.sv =====
// Result channel of running_sample_statistics: one statistics item per set.
// Depends on rss_pkg.
interface rss_out_if;
  import rss_pkg::*;

  logic    valid;
  logic    ready;
  sample_t min_value;
  sample_t max_value;
  sample_t mean_value;
  sd_t     std_deviation;
  count_t  valid_count;
  logic    no_data;
  logic    count_overflow;

  modport source (output valid, output min_value, output max_value, output mean_value,
                  output std_deviation, output valid_count, output no_data,
                  output count_overflow, input ready);
  modport sink   (input valid, input min_value, input max_value, input mean_value,
                  input std_deviation, input valid_count, input no_data,
                  input count_overflow, output ready);
endinterface

// ===== hw/rtl/rss_div.sv =====
// Restoring divider, one quotient bit per cycle: SQS_BITS by COUNT_BITS unsigned.
// Depends on rss_pkg. Divisor must be nonzero.
module rss_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rss_pkg::sqs_t   dividend_i,
  input  rss_pkg::count_t divisor_i,
  output rss_pkg::sqs_t   quotient_o,
  output logic           done_o
);
  import rss_pkg::*;

  sqs_t                    quo_q, quo_d;
  count_t                  rem_q, rem_d;
  count_t                  dvs_q, dvs_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     diff;
  logic                    fits;

  always_comb begin
    trial = {rem_q, quo_q[SQS_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};

    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = DIV_CNT_BITS'(DIV_STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[SQS_BITS-2:0], fits};
      rem_d = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      cnt_d = cnt_q - DIV_CNT_BITS'(1);
      if (cnt_q == DIV_CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// ===== hw/rtl/rss_isqrt.sv =====
// Integer floor square root of an SQS_BITS word, two radicand bits per cycle.
// Depends on rss_pkg.
module rss_isqrt (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rss_pkg::sqs_t  radicand_i,
  output rss_pkg::root_t root_o,
  output logic          done_o
);
  import rss_pkg::*;

  sqs_t            v_q, v_d;
  sqs_t            res_q, res_d;
  sqs_t            bit_q, bit_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [SQS_BITS:0] trial;
  logic            ge;

  always_comb begin
    trial = {1'b0, res_q} + {1'b0, bit_q};
    ge    = {1'b0, v_q} >= trial;

    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = radicand_i;
      res_d  = '0;
      bit_d  = ROOT_BIT0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        v_d   = v_q - trial[SQS_BITS-1:0];
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      // bit 0 is the final step
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign root_o = res_q[ROOT_BITS-1:0];
  assign done_o = done_q;

endmodule

// ===== hw/rtl/rss_ctrl.sv =====
// Controller of running_sample_statistics: accepts items and sequences the
// end-of-set divide, square and root steps. Depends on rss_pkg.
module rss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  rss_pkg::dp_sts_t sts_i,
  output rss_pkg::dp_cmd_t cmd_o
);
  import rss_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_last_i) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = sts_i.cnt_zero ? ST_EMIT : ST_MEAN_GO;
      end
      ST_MEAN_GO: state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (sts_i.div_done) state_d = sts_i.cnt_one ? ST_EMIT : ST_SQ_GO;
      end
      ST_SQ_GO: state_d = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (sts_i.div_done) state_d = ST_ROOT_GO;
      end
      ST_ROOT_GO: state_d = ST_ROOT_WAIT;
      ST_ROOT_WAIT: begin
        if (sts_i.root_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    cmd_o.mul_mean = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_MEAN_GO: cmd_o.div_start = 1'b1;
      ST_MEAN_WAIT: cmd_o.load_mean = sts_i.div_done;
      ST_SQ_GO: begin
        cmd_o.div_start  = 1'b1;
        cmd_o.div_sel_sq = 1'b1;
      end
      ST_ROOT_GO: cmd_o.root_start = 1'b1;
      ST_ROOT_WAIT: cmd_o.load_sd = sts_i.root_done;
      ST_EMIT: begin
        cmd_o.load_out  = sts_i.out_free;
        cmd_o.clear_acc = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/rss_datapath.sv =====
// Datapath of running_sample_statistics: accumulators, shared squarer,
// divider and root units, and the result register. Depends on rss_pkg,
// rss_div and rss_isqrt.
module rss_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rss_pkg::dp_cmd_t cmd_i,
  output rss_pkg::dp_sts_t sts_o,
  input  rss_pkg::sample_t sample_value_i,
  input  logic             sample_present_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output rss_pkg::result_t result_o
);
  import rss_pkg::*;

  sample_t min_q, max_q;
  sum_t    sum_q;
  sqs_t    sqs_q;
  count_t  cnt_q;
  logic    ovf_q;
  logic    sq_pend_q;
  prod_t   prod_q;
  sample_t mean_q;
  sd_t     sd_q;
  logic    out_valid_q;
  result_t res_q;

  logic            cnt_full;
  logic            upd;
  sample_t         mul_a;
  uprod_t          prod_u;
  logic [SQS_BITS:0] sqs_sum;
  logic            sum_neg;
  usum_t           abs_sum;
  sqs_t            dividend;
  sqs_t            div_quo;
  logic            div_done;
  sqs_t            m2;
  sqs_t            variance;
  root_t           root;
  logic            root_done;
  sample_t         quo_low;

  assign cnt_full = &cnt_q;
  assign upd      = cmd_i.take && sample_present_i && !cnt_full;

  // one multiplier: squares the incoming sample, later the mean
  assign mul_a   = cmd_i.mul_mean ? mean_q : sample_value_i;
  assign prod_u  = uprod_t'(prod_q);
  assign sqs_sum = {1'b0, sqs_q} + (SQS_BITS+1)'(prod_u);

  assign sum_neg  = sum_q[SUM_BITS-1];
  assign abs_sum  = sum_neg ? usum_t'(-sum_q) : usum_t'(sum_q);
  assign dividend = cmd_i.div_sel_sq ? sqs_q : sqs_t'(abs_sum);
  assign quo_low  = sample_t'(div_quo[SAMPLE_BITS-1:0]);

  assign m2       = sqs_t'(prod_u);
  assign variance = (div_quo > m2) ? (div_quo - m2) : '0;

  rss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  rss_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.root_start),
    .radicand_i (variance),
    .root_o     (root),
    .done_o     (root_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= SAMPLE_MAX;
      max_q     <= SAMPLE_MIN;
      sum_q     <= '0;
      sqs_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      sq_pend_q <= 1'b0;
    end else if (cmd_i.clear_acc) begin
      min_q     <= SAMPLE_MAX;
      max_q     <= SAMPLE_MIN;
      sum_q     <= '0;
      sqs_q     <= '0;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      sq_pend_q <= 1'b0;
    end else begin
      sq_pend_q <= upd;
      if (upd) begin
        if (sample_value_i < min_q) min_q <= sample_value_i;
        if (sample_value_i > max_q) max_q <= sample_value_i;
        sum_q <= sum_q + sum_t'(sample_value_i);
        cnt_q <= cnt_q + count_t'(1);
      end
      if (cmd_i.take && sample_present_i && cnt_full) ovf_q <= 1'b1;
      // square of the previous item, held in prod_q, is added in the cycle after its acceptance
      if (sq_pend_q) begin
        sqs_q <= sqs_sum[SQS_BITS] ? '1 : sqs_sum[SQS_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_t'(mul_a) * prod_t'(mul_a);
    if (cmd_i.load_mean) mean_q <= sum_neg ? -quo_low : quo_low;
    if (cmd_i.load_sd) begin
      sd_q <= (root > root_t'(SD_MAX)) ? SD_MAX : sd_t'(root);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cnt_q == '0) begin
        res_q <= '{no_data: 1'b1, default: '0};
      end else begin
        res_q.min_value      <= min_q;
        res_q.max_value      <= max_q;
        res_q.mean_value     <= mean_q;
        res_q.std_deviation  <= (cnt_q == count_t'(1)) ? '0 : sd_q;
        res_q.valid_count    <= cnt_q;
        res_q.no_data        <= 1'b0;
        res_q.count_overflow <= ovf_q;
      end
    end
  end

  assign sts_o.cnt_zero  = (cnt_q == '0);
  assign sts_o.cnt_one   = (cnt_q == count_t'(1));
  assign sts_o.div_done  = div_done;
  assign sts_o.root_done = root_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

// ===== hw/rtl/running_sample_statistics.sv =====
// Running min, max, truncated mean and population standard deviation over sets
// of signed samples with 8 fraction bits. Ordinary items are taken one per
// cycle; the square of each sample is folded into the sum of squares in the
// cycle after it is taken. The item flagged last_of_set closes the set: the
// block then drops ready while, for a nonempty set, one shared restoring
// divider runs at one quotient bit per cycle for the mean and, for sets of
// two or more samples, again for the mean square, after which the root
// unit runs 32 two-bit steps. The result sits in an output register, so a
// set can close while the previous result is still waiting; the block then
// holds until the result register frees up. Depends on rss_pkg, rss_in_if,
// rss_out_if, rss_ctrl and rss_datapath.
module running_sample_statistics (
  input  logic      clk_i,
  input  logic      rst_ni,
  rss_in_if.sink    in_i,
  rss_out_if.source out_o
);
  import rss_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  result_t result;
  logic    out_valid;

  rss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_of_set),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rss_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_value_i   (in_i.sample_value),
    .sample_present_i (in_i.sample_present),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_valid),
    .result_o         (result)
  );

  assign out_o.valid          = out_valid;
  assign out_o.min_value      = result.min_value;
  assign out_o.max_value      = result.max_value;
  assign out_o.mean_value     = result.mean_value;
  assign out_o.std_deviation  = result.std_deviation;
  assign out_o.valid_count    = result.valid_count;
  assign out_o.no_data        = result.no_data;
  assign out_o.count_overflow = result.count_overflow;

  // closing a set always stalls the input for the end-of-set work
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.last_of_set |=> !in_i.ready)
    else $error("input ready right after a set closed");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.no_data |->
      out_o.min_value <= out_o.max_value && out_o.valid_count != '0)
    else $error("result with min above max or zero count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.no_data |->
      out_o.valid_count == '0 && out_o.std_deviation == '0 && !out_o.count_overflow)
    else $error("empty set result carries data");

  a_single_sd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.no_data && out_o.valid_count == count_t'(1) |->
      out_o.std_deviation == '0 && out_o.min_value == out_o.mean_value)
    else $error("single-sample set with nonzero deviation");

endmodule
